@@ sv/tbr_pkg.sv @@
// Shared types, widths, codes and saturation helpers of the triangle rasterizer.
// Used by the divider and the top level; no dependencies.
`default_nettype none
package tbr_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned WEIGHT_W  = 18;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned OUT_USER_W = 2;

  // vertex deltas, edge products, shared multiplier and accumulator
  localparam int unsigned DELTA_W = 13;
  localparam int unsigned EDGE_W  = 28;
  localparam int unsigned MULB_W  = 16;
  localparam int unsigned PROD_W  = EDGE_W + MULB_W;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned WFRAC   = 16;
  // quotient magnitude bits and signed quotient width
  localparam int unsigned QUO_W   = 18;
  localparam int unsigned RES_W   = QUO_W + 1;

  localparam logic [CFG_W-1:0] SCREEN_RESET = 9'd256;
  localparam logic signed [DEPTH_W-1:0]  DEPTH_ONE      = 16'sd16384;
  localparam logic signed [DEPTH_W-1:0]  DEPTH_NEG_ONE  = -16'sd16384;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_NEG_ONE = -18'sd65536;

  localparam logic signed [RES_W-1:0] W_SAT_HI = 19'sd131071;
  localparam logic signed [RES_W-1:0] W_SAT_LO = -19'sd131072;
  localparam logic signed [RES_W-1:0] D_SAT_HI = 19'sd32767;
  localparam logic signed [RES_W-1:0] D_SAT_LO = -19'sd32768;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_W = 2'd0,
    CFG_SCREEN_H = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_TEST
  } state_e;

  function automatic logic signed [WEIGHT_W-1:0] sat_weight(input logic signed [RES_W-1:0] v);
    if (v > W_SAT_HI) return W_SAT_HI[WEIGHT_W-1:0];
    else if (v < W_SAT_LO) return W_SAT_LO[WEIGHT_W-1:0];
    else return v[WEIGHT_W-1:0];
  endfunction

  function automatic logic signed [DEPTH_W-1:0] sat_depth(input logic signed [RES_W-1:0] v);
    if (v > D_SAT_HI) return D_SAT_HI[DEPTH_W-1:0];
    else if (v < D_SAT_LO) return D_SAT_LO[DEPTH_W-1:0];
    else return v[DEPTH_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/tbr_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module tbr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/tbr_div.sv @@
// Sequential signed divider with round-to-nearest (ties away from zero) and
// saturated quotient magnitude. Depends on tbr_pkg.
`default_nettype none
module tbr_div
  import tbr_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [ACC_W-1:0]  num_i,
  input  wire logic signed [EDGE_W-1:0] den_i,
  output logic                          done_o,
  output logic signed [RES_W-1:0]       quo_o
);

  localparam int unsigned REM_W = ACC_W + 2;
  localparam int unsigned CNT_W = $clog2(QUO_W + 2);

  logic [REM_W-1:0]  rem_q, dsh_q;
  logic [QUO_W-1:0]  q_q;
  logic              ovf_q, neg_q, busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [ACC_W-1:0]  num_mag;
  logic [EDGE_W-1:0] den_mag;
  logic [REM_W-1:0]  rem_init, dsh_init;
  logic              ge;
  logic [QUO_W-1:0]  mag;

  assign num_mag  = num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
  assign den_mag  = den_i[EDGE_W-1] ? EDGE_W'(-den_i) : EDGE_W'(den_i);
  // rounding: (2|n| + |d|) / (2|d|)
  assign rem_init = (REM_W'(num_mag) << 1) + REM_W'(den_mag);
  assign dsh_init = REM_W'(den_mag) << (QUO_W + 1);
  assign ge       = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUO_W + 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init;
      dsh_q <= dsh_init;
      q_q   <= '0;
      ovf_q <= 1'b0;
      neg_q <= num_i[ACC_W-1] ^ den_i[EDGE_W-1];
    end else if (busy_q) begin
      // first pass only checks that the quotient fits
      if (cnt_q == CNT_W'(QUO_W + 1)) begin
        ovf_q <= ge;
      end else begin
        q_q <= {q_q[QUO_W-2:0], ge};
        if (ge) begin
          rem_q <= rem_q - dsh_q;
        end
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign mag    = ovf_q ? {QUO_W{1'b1}} : q_q;
  assign quo_o  = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign done_o = done_q;

endmodule
`default_nettype wire

@@ sv/triangle_bbox_rasterizer_depth_test.sv @@
// Triangle bounding-box rasterizer with barycentric weights and depth test.
// Depends on tbr_pkg, tbr_ram (depth store) and tbr_div (rounding divider).
//
// After reset the depth store is swept to 1.0, one entry per cycle; no item is
// accepted until the sweep finishes, while configuration writes are always
// taken. A step item runs the shared multiplier for the edge products and the
// depth numerator, then four passes through the bit-serial divider (three
// weights and the depth), then the read-modify-write of the depth store; with
// a zero determinant the divider is skipped. The next item is taken while a
// result waits at the output.
`default_nettype none
module triangle_bbox_rasterizer_depth_test
  import tbr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // s_axis_tdata: vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
  //               vert0_depth, vert1_depth, vert2_depth
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                  s_axis_tuser_i,   // req_type
  // m_axis_tdata: pixel_x, pixel_y, frag_depth, weight0, weight1, weight2, pad
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic [OUT_USER_W-1:0]      m_axis_tuser_o,   // covered, depth_written
  output logic                       m_axis_tlast_o,   // last_pixel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned XW     = $clog2(MAX_WIDTH);
  localparam int unsigned YW     = $clog2(MAX_HEIGHT);
  localparam int unsigned DEPTH_N = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW     = $clog2(DEPTH_N);
  localparam int unsigned PXE_W  = XW + PIX_W;
  localparam int unsigned PYE_W  = YW + PIX_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH_N - 1);

  // multiplier sequence
  localparam logic [3:0] PH_AXQY = 4'd0;
  localparam logic [3:0] PH_QXAY = 4'd1;
  localparam logic [3:0] PH_QXBY = 4'd2;
  localparam logic [3:0] PH_BXQY = 4'd3;
  localparam logic [3:0] PH_BXAY = 4'd4;
  localparam logic [3:0] PH_AXBY = 4'd5;
  localparam logic [3:0] PH_CZ   = 4'd6;
  localparam logic [3:0] PH_N0   = 4'd7;
  localparam logic [3:0] PH_Z0   = 4'd8;
  localparam logic [3:0] PH_Z1   = 4'd9;
  localparam logic [3:0] PH_Z2   = 4'd10;
  localparam logic [3:0] PH_LAST = 4'd11;

  localparam logic [1:0] DIV_W0 = 2'd0;
  localparam logic [1:0] DIV_W1 = 2'd1;
  localparam logic [1:0] DIV_W2 = 2'd2;
  localparam logic [1:0] DIV_FD = 2'd3;

  function automatic logic [DELTA_W-1:0] clamp_box(input logic signed [DELTA_W-1:0] m,
                                                   input logic [DELTA_W-1:0] hi);
    if (m < 0) return '0;
    else if (m > $signed(hi)) return hi;
    else return m;
  endfunction

  // ---------------- registers ----------------
  state_e state_q, state_d;
  logic [3:0]    ph_q;
  logic [1:0]    sel_q;
  logic          div_run_q;
  logic [AW-1:0] clr_q;
  logic          active_q;
  logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [XW-1:0] px_q, xmin_q, xmax_q;
  logic [YW-1:0] py_q, ymin_q, ymax_q;
  logic signed [COORD_W-1:0] vx_q [3];
  logic signed [COORD_W-1:0] vy_q [3];
  logic signed [DEPTH_W-1:0] vz_q [3];
  logic signed [DELTA_W-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [EDGE_W-1:0]  cx_q, cy_q, cz_q, n0_q;
  logic signed [WEIGHT_W-1:0] w_q [3];
  logic signed [DEPTH_W-1:0]  fd_q;
  logic                    out_valid_q, out_last_q;
  logic [OUT_DATA_W-1:0]   out_data_q;
  logic [OUT_USER_W-1:0]   out_user_q;

  // ---------------- input unpack and box ----------------
  logic signed [COORD_W-1:0] in_x [3];
  logic signed [COORD_W-1:0] in_y [3];
  logic signed [DEPTH_W-1:0] in_z [3];
  logic signed [DELTA_W-1:0] mnx, mny, mxx, mxy;
  logic [DELTA_W-1:0] scr_w, scr_h, hi_x, hi_y;
  logic [DELTA_W-1:0] bx_lo, bx_hi, by_lo, by_hi;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_x[i] = s_axis_tdata_i[2*COORD_W*i +: COORD_W];
      in_y[i] = s_axis_tdata_i[2*COORD_W*i + COORD_W +: COORD_W];
      in_z[i] = s_axis_tdata_i[6*COORD_W + DEPTH_W*i +: DEPTH_W];
    end
  end

  always_comb begin
    mnx = DELTA_W'(in_x[0]);
    mxx = DELTA_W'(in_x[0]);
    mny = DELTA_W'(in_y[0]);
    mxy = DELTA_W'(in_y[0]);
    for (int i = 1; i < 3; i++) begin
      if (DELTA_W'(in_x[i]) < mnx) mnx = DELTA_W'(in_x[i]);
      if (DELTA_W'(in_x[i]) > mxx) mxx = DELTA_W'(in_x[i]);
      if (DELTA_W'(in_y[i]) < mny) mny = DELTA_W'(in_y[i]);
      if (DELTA_W'(in_y[i]) > mxy) mxy = DELTA_W'(in_y[i]);
    end
  end

  always_comb begin
    if (cfg_w_q == '0) scr_w = DELTA_W'(1);
    else if (DELTA_W'(cfg_w_q) > DELTA_W'(MAX_WIDTH)) scr_w = DELTA_W'(MAX_WIDTH);
    else scr_w = DELTA_W'(cfg_w_q);
    if (cfg_h_q == '0) scr_h = DELTA_W'(1);
    else if (DELTA_W'(cfg_h_q) > DELTA_W'(MAX_HEIGHT)) scr_h = DELTA_W'(MAX_HEIGHT);
    else scr_h = DELTA_W'(cfg_h_q);
  end

  assign hi_x  = scr_w - DELTA_W'(1);
  assign hi_y  = scr_h - DELTA_W'(1);
  assign bx_lo = clamp_box(mnx, hi_x);
  assign bx_hi = clamp_box(mxx, hi_x);
  assign by_lo = clamp_box(mny, hi_y);
  assign by_hi = clamp_box(mxy, hi_y);

  // ---------------- shared multiplier ----------------
  logic signed [DELTA_W-1:0] qx, qy;
  logic signed [EDGE_W-1:0]  mul_a;
  logic signed [MULB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  mul_res;

  assign qx = DELTA_W'(vx_q[0]) - $signed(DELTA_W'(px_q));
  assign qy = DELTA_W'(vy_q[0]) - $signed(DELTA_W'(py_q));

  always_comb begin
    unique case (ph_q)
      PH_AXQY: begin mul_a = EDGE_W'(ax_q); mul_b = MULB_W'(qy);   end
      PH_QXAY: begin mul_a = EDGE_W'(qx);   mul_b = MULB_W'(ay_q); end
      PH_QXBY: begin mul_a = EDGE_W'(qx);   mul_b = MULB_W'(by_q); end
      PH_BXQY: begin mul_a = EDGE_W'(bx_q); mul_b = MULB_W'(qy);   end
      PH_BXAY: begin mul_a = EDGE_W'(bx_q); mul_b = MULB_W'(ay_q); end
      PH_AXBY: begin mul_a = EDGE_W'(ax_q); mul_b = MULB_W'(by_q); end
      PH_Z0:   begin mul_a = n0_q;          mul_b = vz_q[0];       end
      PH_Z1:   begin mul_a = cy_q;          mul_b = vz_q[1];       end
      PH_Z2:   begin mul_a = cx_q;          mul_b = vz_q[2];       end
      default: begin mul_a = '0;            mul_b = '0;            end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // ---------------- divider ----------------
  logic                    div_start, div_done;
  logic signed [ACC_W-1:0] div_num;
  logic signed [RES_W-1:0] div_quo;

  always_comb begin
    unique case (sel_q)
      DIV_W0:  div_num = ACC_W'(n0_q) <<< WFRAC;
      DIV_W1:  div_num = ACC_W'(cy_q) <<< WFRAC;
      DIV_W2:  div_num = ACC_W'(cx_q) <<< WFRAC;
      default: div_num = acc_q;
    endcase
  end

  tbr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (cz_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // ---------------- depth store ----------------
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, pix_addr;
  logic [DEPTH_W-1:0]         ram_wdata, ram_rdata;

  assign pix_addr = AW'(py_q) * AW'(MAX_WIDTH) + AW'(px_q);

  tbr_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (DEPTH_N)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pix_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------- test stage ----------------
  logic                       in_fire, out_free, test_fire;
  logic                       cz_zero, cov, wr, last;
  logic signed [RES_W-1:0]    zneg;
  logic signed [DEPTH_W-1:0]  fd_fin;
  logic signed [WEIGHT_W-1:0] w_fin [3];
  logic [PXE_W-1:0]           px_wide;
  logic [PYE_W-1:0]           py_wide;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign cz_zero  = (cz_q == '0);
  assign zneg     = -(RES_W'(vz_q[0]) + RES_W'(vz_q[1]) + RES_W'(vz_q[2]));

  always_comb begin
    fd_fin = cz_zero ? sat_depth(zneg) : fd_q;
    for (int i = 0; i < 3; i++) begin
      w_fin[i] = cz_zero ? WEIGHT_NEG_ONE : w_q[i];
    end
    if (cz_zero) begin
      cov = 1'b0;
    end else if (cz_q < 0) begin
      cov = (n0_q <= 0) && (cy_q <= 0) && (cx_q <= 0);
    end else begin
      cov = (n0_q >= 0) && (cy_q >= 0) && (cx_q >= 0);
    end
    wr   = cov && ($signed(ram_rdata) >= fd_fin) && (fd_fin >= DEPTH_NEG_ONE);
    last = (px_q == xmax_q) && (py_q == ymax_q);
  end

  assign px_wide = PXE_W'(px_q);
  assign py_wide = PYE_W'(py_q);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == CLR_LAST) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire && s_axis_tuser_i == REQ_STEP && active_q) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (ph_q == PH_LAST) state_d = cz_zero ? ST_TEST : ST_DIV;
      end
      ST_DIV: if (div_done && sel_q == DIV_FD) state_d = ST_TEST;
      ST_TEST: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    ram_re          = (state_q == ST_MUL) && (ph_q == PH_AXQY);
    div_start       = (state_q == ST_DIV) && !div_run_q;
    test_fire       = (state_q == ST_TEST) && out_free;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = DEPTH_ONE;
    end else begin
      ram_we    = test_fire && wr;
      ram_waddr = pix_addr;
      ram_wdata = fd_fin;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ph_q        <= '0;
      sel_q       <= '0;
      div_run_q   <= 1'b0;
      clr_q       <= '0;
      active_q    <= 1'b0;
      cfg_w_q     <= SCREEN_RESET;
      cfg_h_q     <= SCREEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_SCREEN_W) cfg_w_q <= cfg_data_i;
        if (cfg_index_i == CFG_SCREEN_H) cfg_h_q <= cfg_data_i;
      end
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (in_fire && s_axis_tuser_i == REQ_LOAD) active_q <= 1'b1;
      ph_q <= (state_q == ST_MUL) ? ph_q + 4'd1 : '0;
      if (state_q != ST_DIV) begin
        sel_q     <= DIV_W0;
        div_run_q <= 1'b0;
      end else if (div_start) begin
        div_run_q <= 1'b1;
      end else if (div_done) begin
        div_run_q <= 1'b0;
        sel_q     <= sel_q + 2'd1;
      end
      if (test_fire) begin
        out_valid_q <= 1'b1;
        if (last) active_q <= 1'b0;
      end else if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tuser_i == REQ_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= in_x[i];
        vy_q[i] <= in_y[i];
        vz_q[i] <= in_z[i];
      end
      ax_q   <= DELTA_W'(in_x[1]) - DELTA_W'(in_x[0]);
      ay_q   <= DELTA_W'(in_y[1]) - DELTA_W'(in_y[0]);
      bx_q   <= DELTA_W'(in_x[2]) - DELTA_W'(in_x[0]);
      by_q   <= DELTA_W'(in_y[2]) - DELTA_W'(in_y[0]);
      xmin_q <= bx_lo[XW-1:0];
      xmax_q <= bx_hi[XW-1:0];
      ymin_q <= by_lo[YW-1:0];
      ymax_q <= by_hi[YW-1:0];
      px_q   <= bx_lo[XW-1:0];
      py_q   <= by_lo[YW-1:0];
    end
    if (state_q == ST_MUL) begin
      prod_q <= mul_res;
      unique case (ph_q)
        PH_QXAY, PH_BXQY, PH_AXBY, PH_Z1: acc_q <= ACC_W'(prod_q);
        PH_Z2, PH_LAST: acc_q <= acc_q + ACC_W'(prod_q);
        PH_QXBY: cx_q <= EDGE_W'(acc_q - ACC_W'(prod_q));
        PH_BXAY: cy_q <= EDGE_W'(acc_q - ACC_W'(prod_q));
        PH_CZ:   cz_q <= EDGE_W'(acc_q - ACC_W'(prod_q));
        PH_N0:   n0_q <= cz_q - cx_q - cy_q;
        default: ;
      endcase
    end
    if (state_q == ST_DIV && div_done) begin
      if (sel_q == DIV_FD) fd_q <= sat_depth(div_quo);
      else w_q[sel_q] <= sat_weight(div_quo);
    end
    if (test_fire) begin
      out_data_q <= {2'b00, w_fin[2], w_fin[1], w_fin[0], fd_fin,
                     py_wide[PIX_W-1:0], px_wide[PIX_W-1:0]};
      out_user_q <= {wr, cov};
      out_last_q <= last;
      // advance: y inner, x outer
      if (!last) begin
        if (py_q >= ymax_q) begin
          py_q <= ymin_q;
          px_q <= px_q + XW'(1);
        end else begin
          py_q <= py_q + YW'(1);
        end
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;
  assign cfg_ready_o     = 1'b1;

endmodule
`default_nettype wire

@@ test/tbr_checker.sv @@
// Checker for the triangle rasterizer: watches the config, input and output channels,
// predicts every pixel result and compares it field by field.
// Depends on tbr_pkg for the request and register codes.
`timescale 1ns / 100ps
module tbr_checker
  import tbr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [119:0] s_tdata_i,
  input  logic         s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [87:0]  m_tdata_i,
  input  logic [1:0]   m_tuser_i,
  input  logic         m_tlast_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [8:0]   cfg_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct {
    logic [7:0]  px;
    logic [7:0]  py;
    logic [15:0] depth;
    logic [17:0] w0;
    logic [17:0] w1;
    logic [17:0] w2;
    logic        cov;
    logic        wr;
    logic        last;
  } pixel_t;

  pixel_t      pixel_q[$];
  logic signed [15:0] zbuf[65536];
  longint      vtx[6];
  longint      vz[3];
  longint      box[4];  // xmin, ymin, xmax, ymax
  longint      walk_x, walk_y;
  bit          walking;
  logic [8:0]  scr_w, scr_h;

  initial fail_count_o = 0;
  initial pending_o = 0;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round to nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    bit     neg;
    longint an, ad, q;
    neg = (num < 0) != (den < 0);
    an  = num < 0 ? -num : num;
    ad  = den < 0 ? -den : den;
    q   = (2 * an + ad) / (2 * ad);
    return neg ? -q : q;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  task automatic latch_triangle(input logic [119:0] d);
    longint w, h;
    w = clampl(scr_w, 1, 256);
    h = clampl(scr_h, 1, 256);
    for (int i = 0; i < 6; i++) vtx[i] = $signed(d[i*12 +: 12]);
    for (int i = 0; i < 3; i++) vz[i] = $signed(d[72 + i*16 +: 16]);
    box[0] = clampl(vtx[0] < vtx[2] ? (vtx[0] < vtx[4] ? vtx[0] : vtx[4])
                                    : (vtx[2] < vtx[4] ? vtx[2] : vtx[4]), 0, w - 1);
    box[1] = clampl(vtx[1] < vtx[3] ? (vtx[1] < vtx[5] ? vtx[1] : vtx[5])
                                    : (vtx[3] < vtx[5] ? vtx[3] : vtx[5]), 0, h - 1);
    box[2] = clampl(vtx[0] > vtx[2] ? (vtx[0] > vtx[4] ? vtx[0] : vtx[4])
                                    : (vtx[2] > vtx[4] ? vtx[2] : vtx[4]), 0, w - 1);
    box[3] = clampl(vtx[1] > vtx[3] ? (vtx[1] > vtx[5] ? vtx[1] : vtx[5])
                                    : (vtx[3] > vtx[5] ? vtx[3] : vtx[5]), 0, h - 1);
    walk_x  = box[0];
    walk_y  = box[1];
    walking = 1'b1;
  endtask

  task automatic shade_pixel();
    longint ax, ay, bx, by, qx, qy, cx, cy, cz, n0, n1, n2, w0, w1, w2, fd;
    bit     cov, wr, last;
    pixel_t r;
    ax = vtx[2] - vtx[0];  ay = vtx[3] - vtx[1];
    bx = vtx[4] - vtx[0];  by = vtx[5] - vtx[1];
    qx = vtx[0] - walk_x;  qy = vtx[1] - walk_y;
    cx = ax * qy - qx * ay;
    cy = qx * by - bx * qy;
    cz = bx * ay - ax * by;
    cov = 1'b0;
    wr  = 1'b0;
    if (cz != 0) begin
      n0 = cz - cx - cy;  n1 = cy;  n2 = cx;
      w0 = round_div(n0 * 65536, cz);
      w1 = round_div(n1 * 65536, cz);
      w2 = round_div(n2 * 65536, cz);
      fd = round_div(vz[0] * n0 + vz[1] * n1 + vz[2] * n2, cz);
      if (cz < 0) cov = n0 <= 0 && n1 <= 0 && n2 <= 0;
      else cov = n0 >= 0 && n1 >= 0 && n2 >= 0;
    end else begin
      w0 = -65536;  w1 = -65536;  w2 = -65536;
      fd = -(vz[0] + vz[1] + vz[2]);
    end
    w0 = clampl(w0, -131072, 131071);
    w1 = clampl(w1, -131072, 131071);
    w2 = clampl(w2, -131072, 131071);
    fd = clampl(fd, -32768, 32767);
    if (cov && zbuf[walk_y * 256 + walk_x] >= fd && fd >= -16384) begin
      zbuf[walk_y * 256 + walk_x] = fd[15:0];
      wr = 1'b1;
    end
    last = walk_x == box[2] && walk_y == box[3];
    r.px = walk_x[7:0];  r.py = walk_y[7:0];  r.depth = fd[15:0];
    r.w0 = w0[17:0];  r.w1 = w1[17:0];  r.w2 = w2[17:0];
    r.cov = cov;  r.wr = wr;  r.last = last;
    pixel_q.push_back(r);
    // advance: y inner, x outer
    if (last) walking = 1'b0;
    else if (walk_y >= box[3]) begin
      walk_y = box[1];
      walk_x = walk_x + 1;
    end else walk_y = walk_y + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 65536; i++) zbuf[i] = 16'sd16384;
      for (int i = 0; i < 6; i++) vtx[i] = 0;
      for (int i = 0; i < 3; i++) vz[i] = 0;
      for (int i = 0; i < 4; i++) box[i] = 0;
      walk_x = 0;
      walk_y = 0;
      walking = 1'b0;
      scr_w = 9'd256;
      scr_h = 9'd256;
      pixel_q.delete();
      pending_o <= 0;
    end else begin
      // outputs first: a result never belongs to an item taken at the same edge
      if (m_tvalid_i && m_tready_i) begin
        if (pixel_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, got 0x%0h", $time, m_tdata_i);
        end else begin
          e = pixel_q.pop_front();
          check_field("pixel_x", e.px, m_tdata_i[7:0]);
          check_field("pixel_y", e.py, m_tdata_i[15:8]);
          check_field("frag_depth", e.depth, m_tdata_i[31:16]);
          check_field("weight0", e.w0, m_tdata_i[49:32]);
          check_field("weight1", e.w1, m_tdata_i[67:50]);
          check_field("weight2", e.w2, m_tdata_i[85:68]);
          check_field("covered", e.cov, m_tuser_i[0]);
          check_field("depth_written", e.wr, m_tuser_i[1]);
          check_field("last_pixel", e.last, m_tlast_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SCREEN_W) scr_w = cfg_data_i;
        else if (cfg_index_i == CFG_SCREEN_H) scr_h = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == REQ_LOAD) latch_triangle(s_tdata_i);
        else if (walking) shade_pixel();
      end
      pending_o <= pixel_q.size();
    end
  end

endmodule

@@ test/tb_triangle_bbox_rasterizer_depth_test.sv @@
// Testbench top for the triangle rasterizer: clock, reset, stimulus and verdict.
// Depends on tbr_pkg, the rasterizer RTL and tbr_checker, which predicts and compares.
`timescale 1ns / 100ps
module tb_triangle_bbox_rasterizer_depth_test;
  import tbr_pkg::*;

  typedef struct packed {
    logic signed [15:0] z2, z1, z0;
    logic signed [11:0] y2, x2, y1, x1, y0, x0;
  } tri_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [119:0] s_tdata = '0;
  logic         s_tuser = REQ_LOAD;
  logic         m_tready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic [1:0]   cfg_index = CFG_SCREEN_W;
  logic [8:0]   cfg_data = '0;
  logic         s_tready, m_tvalid, m_tlast, cfg_ready;
  logic [87:0]  m_tdata;
  logic [1:0]   m_tuser;
  int           fail_count, pending;

  bit quiet = 1'b0;
  int stall_left = 0;
  int loads = 0, steps = 0, phases = 0, items = 0;
  int scr_w = 256, scr_h = 256;  // effective (clamped) screen size

  triangle_bbox_rasterizer_depth_test DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser), .m_axis_tlast_o(m_tlast),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  tbr_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .m_tuser_i(m_tuser), .m_tlast_i(m_tlast),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  // result side: random stall bursts, none in the quiet tail
  always @(posedge clk_i) begin
    if (quiet) m_tready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 17);
      m_tready <= 1'b0;
    end else m_tready <= 1'b1;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int walk_len(tri_t t);
    int x0, x1, y0, y1;
    x0 = clampi(t.x0 < t.x1 ? (t.x0 < t.x2 ? t.x0 : t.x2) : (t.x1 < t.x2 ? t.x1 : t.x2),
                0, scr_w - 1);
    x1 = clampi(t.x0 > t.x1 ? (t.x0 > t.x2 ? t.x0 : t.x2) : (t.x1 > t.x2 ? t.x1 : t.x2),
                0, scr_w - 1);
    y0 = clampi(t.y0 < t.y1 ? (t.y0 < t.y2 ? t.y0 : t.y2) : (t.y1 < t.y2 ? t.y1 : t.y2),
                0, scr_h - 1);
    y1 = clampi(t.y0 > t.y1 ? (t.y0 > t.y2 ? t.y0 : t.y2) : (t.y1 > t.y2 ? t.y1 : t.y2),
                0, scr_h - 1);
    return (x1 - x0 + 1) * (y1 - y0 + 1);
  endfunction

  // hold valid high across back-to-back items; drop it only for a gap
  task automatic send_item(input logic req, input logic [119:0] data);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= data;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic paint(input tri_t t, input int n);
    send_item(REQ_LOAD, t);
    loads++;
    items++;
    for (int i = 0; i < n; i++) begin
      send_item(REQ_STEP, 120'({$urandom, $urandom, $urandom, $urandom}));
      steps++;
      items++;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // a trailing step may still be busy without producing a result
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_screen(input logic [8:0] w, input logic [8:0] h);
    drain();
    write_reg(CFG_SCREEN_W, w);
    write_reg(CFG_SCREEN_H, h);
    scr_w = clampi(w, 1, 256);
    scr_h = clampi(h, 1, 256);
    phases++;
  endtask

  function automatic tri_t mk_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                  int za, int zb, int zc);
    tri_t t;
    t.x0 = 12'(ax); t.y0 = 12'(ay); t.x1 = 12'(bx); t.y1 = 12'(by);
    t.x2 = 12'(cx); t.y2 = 12'(cy);
    t.z0 = 16'(za); t.z1 = 16'(zb); t.z2 = 16'(zc);
    return t;
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    int   bx, by, zsel;
    zsel = $urandom_range(0, 2);
    if (scr_w * scr_h <= 16 && $urandom_range(0, 1)) begin
      t = 120'({$urandom, $urandom, $urandom, $urandom});  // any coordinates, box clamps small
    end else begin
      bx = $urandom_range(0, scr_w + 5) - 3;
      by = $urandom_range(0, scr_h + 5) - 3;
      t.x0 = 12'(bx + $urandom_range(0, 4));  t.y0 = 12'(by + $urandom_range(0, 4));
      t.x1 = 12'(bx + $urandom_range(0, 4));  t.y1 = 12'(by + $urandom_range(0, 4));
      t.x2 = 12'(bx + $urandom_range(0, 4));  t.y2 = 12'(by + $urandom_range(0, 4));
    end
    if (zsel == 0) begin
      t.z0 = 16'($urandom);  t.z1 = 16'($urandom);  t.z2 = 16'($urandom);
    end else begin
      t.z0 = 16'($urandom_range(0, 40000) - 20000);
      t.z1 = 16'($urandom_range(0, 40000) - 20000);
      t.z2 = 16'($urandom_range(0, 40000) - 20000);
    end
    return t;
  endfunction

  initial begin
    tri_t t;
    int   n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: step with no triangle, then small cases at full screen
    send_item(REQ_STEP, '0);
    t = mk_tri(10, 10, 11, 10, 10, 11, 0, 8192, 16384);
    paint(t, walk_len(t));
    paint(t, walk_len(t));                               // equal depth still passes
    paint(mk_tri(20, 20, 20, 21, 21, 20, -16384, -16384, -16384), 4);  // clockwise, at -1.0
    paint(mk_tri(30, 30, 31, 30, 32, 30, 32767, 32767, 32767), 3);     // zero determinant
    paint(mk_tri(40, 40, 41, 40, 40, 41, -32768, -32768, -32768), 4);  // below -1.0
    paint(t, 1);                                         // load during a walk
    paint(mk_tri(12, 12, 13, 12, 12, 13, 100, 200, 300), 4);
    send_item(REQ_STEP, '1);                             // step after the walk ended

    set_screen(9'd2, 9'd2);
    t = mk_tri(-2048, -2048, 2047, 2047, -2048, 2047, -32768, 32767, 0);
    paint(t, walk_len(t));
    t = mk_tri(2000, 5, 2047, 6, 2010, 100, 1, 2, 3);  // off screen: clamped box
    paint(t, walk_len(t));
    set_screen(9'd0, 9'd1);
    t = mk_tri(-5, -5, 9, 3, 2, 7, 4000, -4000, 0);
    paint(t, walk_len(t));
    set_screen(9'd511, 9'd256);
    paint(random_tri(), 0);

    // random phases over screen settings
    while (items < 1900) begin
      if (items > 1600) quiet = 1'b1;
      if ($urandom_range(0, 1)) set_screen($urandom_range(1, 6), $urandom_range(1, 6));
      else set_screen($urandom_range(0, 511), $urandom_range(0, 511));
      repeat ($urandom_range(6, 20)) begin
        t = random_tri();
        n = walk_len(t);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);  // cut short by next load
        paint(t, n);
        if ($urandom_range(0, 9) == 0) begin
          send_item(REQ_STEP, 120'({$urandom, $urandom, $urandom, $urandom}));
        end
      end
    end

    drain();
    $display("Ran %0d loads and %0d pixel steps over %0d screen settings,", loads, steps, phases);
    $display("with random gaps and stalls on both streams before a quiet tail.");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ triangle_bbox_rasterizer_depth_test.f @@
sv/tbr_pkg.sv
sv/tbr_ram.sv
sv/tbr_div.sv
sv/triangle_bbox_rasterizer_depth_test.sv
test/tbr_checker.sv
test/tb_triangle_bbox_rasterizer_depth_test.sv
